@@ hdl/gbb_pkg.sv @@
package gbb_pkg;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned DimBits    = 8;
  localparam int unsigned CovBits    = 8;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned ModeBits   = 2;
  localparam int unsigned SizeBits   = 2;
  localparam int unsigned PStrBits   = 3;
  localparam int unsigned LStrBits   = 15;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned QDepth     = 4;

  localparam int unsigned PxOffBits  = CoordBits + PStrBits;
  localparam int unsigned PyOffBits  = CoordBits + LStrBits;

  localparam logic [DimBits-1:0] GlyphDimMax = 8'hff;

  localparam logic [CfgIdxBits-1:0] CFG_PIXEL_MODE    = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_FRAME_BASE    = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_PIXEL_STRIDE  = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_LINE_STRIDE   = 3'd5;

  localparam logic [ModeBits-1:0] MODE_8BPP   = 2'd0;
  localparam logic [ModeBits-1:0] MODE_RGB565 = 2'd1;
  localparam logic [ModeBits-1:0] MODE_32BPP  = 2'd2;
  localparam logic [ModeBits-1:0] MODE_NONE   = 2'd3;

  localparam logic [SizeBits-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SizeBits-1:0] SIZE_HALF = 2'd1;
  localparam logic [SizeBits-1:0] SIZE_WORD = 2'd2;

  typedef struct packed {
    logic [ModeBits-1:0]  pixel_mode;
    logic [CoordBits-1:0] screen_width;
    logic [CoordBits-1:0] screen_height;
    logic [WordBits-1:0]  frame_base;
    logic [PStrBits-1:0]  pixel_stride;
    logic [LStrBits-1:0]  line_stride;
  } cfg_t;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [WordBits-1:0]  data;
    logic [SizeBits-1:0]  size;
  } req_t;

  function automatic logic [DimBits-1:0] eff_dim(input logic [DimBits-1:0] d);
    logic [DimBits-1:0] r;
    r = (d > GlyphDimMax) ? GlyphDimMax : d;
    if (r == '0) begin
      r = {{(DimBits-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

endpackage

@@ hdl/gbb_front.sv @@
module gbb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gbb_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gbb_pkg::CoordBits-1:0]  glyph_left_i,
  input  logic [gbb_pkg::CoordBits-1:0]  glyph_top_i,
  input  logic [gbb_pkg::DimBits-1:0]    glyph_width_i,
  input  logic [gbb_pkg::DimBits-1:0]    glyph_height_i,
  input  logic [gbb_pkg::CovBits-1:0]    coverage_i,
  input  logic [gbb_pkg::WordBits-1:0]   pixel_color_i,
  input  logic                           full_i,
  output logic                           push_o,
  output gbb_pkg::req_t                  push_req_o
);

  localparam int unsigned CB = gbb_pkg::CoordBits;
  localparam int unsigned DB = gbb_pkg::DimBits;

  logic [DB-1:0] col_q, col_d, row_q, row_d;
  logic [DB-1:0] col_inc, row_inc, w_eff, h_eff;
  logic [CB:0]   x_s, y_s;
  logic          accept, on_screen;
  logic [gbb_pkg::WordBits-1:0] color;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // screen position, one bit wider to carry the sign
  assign x_s = {glyph_left_i[CB-1], glyph_left_i} + {{(CB+1-DB){1'b0}}, col_q};
  assign y_s = {glyph_top_i[CB-1], glyph_top_i} + {{(CB+1-DB){1'b0}}, row_q};

  assign on_screen = ~x_s[CB] & ~y_s[CB] &
                     (x_s[CB-1:0] < cfg_i.screen_width) &
                     (y_s[CB-1:0] < cfg_i.screen_height);

  assign color = pixel_color_i;

  always_comb begin
    push_req_o.x = x_s[CB-1:0];
    push_req_o.y = y_s[CB-1:0];
    case (cfg_i.pixel_mode)
      gbb_pkg::MODE_8BPP: begin
        push_req_o.data = {24'h0, color[7:0]};
        push_req_o.size = gbb_pkg::SIZE_BYTE;
      end
      gbb_pkg::MODE_RGB565: begin
        push_req_o.data = {16'h0, color[23:19], color[15:10], color[7:3]};
        push_req_o.size = gbb_pkg::SIZE_HALF;
      end
      default: begin
        push_req_o.data = color;
        push_req_o.size = gbb_pkg::SIZE_WORD;
      end
    endcase
  end

  assign push_o = accept & on_screen & (coverage_i != '0) &
                  (cfg_i.pixel_mode != gbb_pkg::MODE_NONE);

  assign w_eff   = gbb_pkg::eff_dim(glyph_width_i);
  assign h_eff   = gbb_pkg::eff_dim(glyph_height_i);
  assign col_inc = col_q + 1'b1;
  assign row_inc = row_q + 1'b1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      col_d = col_inc;
      if (col_inc >= w_eff || col_inc == '0) begin
        col_d = '0;
        row_d = row_inc;
        if (row_inc >= h_eff || row_inc == '0) begin
          row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ hdl/gbb_fifo.sv @@
module gbb_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbb_pkg::req_t push_req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output gbb_pkg::req_t pop_req_o
);

  localparam int unsigned Depth = gbb_pkg::QDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  gbb_pkg::req_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;
  assign pop_req_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/gbb_back.sv @@
module gbb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbb_pkg::cfg_t                 cfg_i,
  input  logic                          empty_i,
  input  gbb_pkg::req_t                 req_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbb_pkg::WordBits-1:0]  write_address_o,
  output logic [gbb_pkg::WordBits-1:0]  write_data_o,
  output logic [gbb_pkg::SizeBits-1:0]  write_size_o
);

  localparam int unsigned WB = gbb_pkg::WordBits;

  logic                          s1_v_q, out_v_q;
  logic [gbb_pkg::PxOffBits-1:0] px_q;
  logic [gbb_pkg::PyOffBits-1:0] py_q;
  logic [WB-1:0]                 s1_data_q, data_q, addr_q;
  logic [gbb_pkg::SizeBits-1:0]  s1_size_q, size_q;
  logic                          out_ready, s1_ready, s1_move;
  logic [WB-1:0]                 addr_d;

  assign out_ready = ~out_v_q | ~out_stall_i;
  assign s1_move   = s1_v_q & out_ready;
  assign s1_ready  = ~s1_v_q | out_ready;
  assign pop_o     = ~empty_i & s1_ready;

  assign addr_d = cfg_i.frame_base
                + WB'(px_q)
                + WB'(py_q);

  // stage 1: offsets; output stage: address add
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      px_q      <= req_i.x * cfg_i.pixel_stride;
      py_q      <= req_i.y * cfg_i.line_stride;
      s1_data_q <= req_i.data;
      s1_size_q <= req_i.size;
    end
    if (s1_move) begin
      addr_q <= addr_d;
      data_q <= s1_data_q;
      size_q <= s1_size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= pop_o;
      end
      if (out_ready) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign write_address_o = addr_q;
  assign write_data_o    = data_q;
  assign write_size_o    = size_q;

endmodule

@@ hdl/glyph_bitmap_blitter.sv @@
// Glyph bitmap blitter.
// Input channel (in_valid_i / in_stall_o): one glyph coverage byte per request,
// row-major, with glyph placement, size and color. A request is taken at a
// clock edge with in_valid_i high and in_stall_o low; column/row counters
// inside the glyph advance on every request and wrap after the last pixel.
// Output channel (out_valid_o / out_stall_i): one framebuffer write per drawn
// pixel (nonzero coverage, on screen, supported mode); other pixels give none.
// Path: a drawn pixel passes the request queue, stage 1 and the output register.
// Throughput: one request per cycle while in_stall_o is low, set by the two-stage
// write pipeline (stride multiplies, then address add) behind a 4-entry request queue.
// When the receiver stalls, the output and stage 1 hold and the queue takes up
// to 4 more writes; once it is full in_stall_o rises for every request until
// the receiver resumes and the queue frees an entry.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i) is to be written by the user
// only while idle (the block does not enforce this); writes to indexes 6 and 7 are ignored.
// Reset: counters at zero, queue and pipeline empty, registers at defaults
// (32bpp, 800x480, base 0, pixel stride 4, line stride 3200).
module glyph_bitmap_blitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbb_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [gbb_pkg::WordBits-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gbb_pkg::CoordBits-1:0]   glyph_left_i,
  input  logic [gbb_pkg::CoordBits-1:0]   glyph_top_i,
  input  logic [gbb_pkg::DimBits-1:0]     glyph_width_i,
  input  logic [gbb_pkg::DimBits-1:0]     glyph_height_i,
  input  logic [gbb_pkg::CovBits-1:0]     coverage_i,
  input  logic [gbb_pkg::WordBits-1:0]    pixel_color_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gbb_pkg::WordBits-1:0]    write_address_o,
  output logic [gbb_pkg::WordBits-1:0]    write_data_o,
  output logic [gbb_pkg::SizeBits-1:0]    write_size_o
);

  gbb_pkg::cfg_t cfg_q;
  gbb_pkg::req_t push_req, pop_req;
  logic          push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode    <= gbb_pkg::MODE_32BPP;
      cfg_q.screen_width  <= 12'd800;
      cfg_q.screen_height <= 12'd480;
      cfg_q.frame_base    <= '0;
      cfg_q.pixel_stride  <= 3'd4;
      cfg_q.line_stride   <= 15'd3200;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gbb_pkg::CFG_PIXEL_MODE:    cfg_q.pixel_mode    <= cfg_data_i[gbb_pkg::ModeBits-1:0];
        gbb_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[gbb_pkg::CoordBits-1:0];
        gbb_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[gbb_pkg::CoordBits-1:0];
        gbb_pkg::CFG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data_i;
        gbb_pkg::CFG_PIXEL_STRIDE:  cfg_q.pixel_stride  <= cfg_data_i[gbb_pkg::PStrBits-1:0];
        gbb_pkg::CFG_LINE_STRIDE:   cfg_q.line_stride   <= cfg_data_i[gbb_pkg::LStrBits-1:0];
        default: begin
        end
      endcase
    end
  end

  gbb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .glyph_left_i   (glyph_left_i),
    .glyph_top_i    (glyph_top_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .coverage_i     (coverage_i),
    .pixel_color_i  (pixel_color_i),
    .full_i         (full),
    .push_o         (push),
    .push_req_o     (push_req)
  );

  gbb_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_req_o  (pop_req)
  );

  gbb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .req_i           (pop_req),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .write_size_o    (write_size_o)
  );

endmodule

@@ hdl/gbb_checker.sv @@
module gbb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_stall_i,
  input logic [gbb_pkg::WordBits-1:0]   write_address_i,
  input logic [gbb_pkg::WordBits-1:0]   write_data_i,
  input logic [gbb_pkg::SizeBits-1:0]   write_size_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("write request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      $stable(write_address_i) && $stable(write_data_i) && $stable(write_size_i))
    else $error("write payload changed while stalled");

  a_size_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> write_size_i == gbb_pkg::SIZE_BYTE ||
                    write_size_i == gbb_pkg::SIZE_HALF ||
                    write_size_i == gbb_pkg::SIZE_WORD)
    else $error("illegal write size");

  a_data_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (write_size_i != gbb_pkg::SIZE_BYTE || write_data_i[31:8] == '0) &&
      (write_size_i != gbb_pkg::SIZE_HALF || write_data_i[31:16] == '0))
    else $error("write data wider than write size");

endmodule

bind glyph_bitmap_blitter gbb_checker u_gbb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .write_address_i (write_address_o),
  .write_data_i    (write_data_o),
  .write_size_i    (write_size_o)
);
